[hw/rtl/dmdpt_pkg.sv]
// shared types and constants for the depth-preferred direct-mapped table
// no dependencies

package dmdpt_pkg;

    // table size, a power of two so the slot is the low key bits
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_LOOKUP = 2'd0;
    localparam kind_t KIND_STORE  = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    // one table slot as held in the ram
    typedef struct packed {
        logic               valid;
        logic [63:0]        key;
        logic signed [31:0] score;
        logic [7:0]         depth;
        logic [7:0]         ntype;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[hw/rtl/direct_mapped_depth_preferred_table_unit.sv]
// top level of the depth-preferred direct-mapped table
// depends on dmdpt_pkg and dmdpt_ram

// Takes one lookup or store transaction per clock cycle while m_ready is high and no clear or sweep
// is pending. The ram read is registered at the accepting edge alongside the transaction in stage
// one, and compare and update act on stage one as it moves into the result register. The slot is
// the low bits of the key. Consecutive transactions to the same slot are forwarded, so no gap is
// needed between them. A clear transaction returns its result, then sweeps all TABLE_ENTRIES
// slots (1024 by default) one slot per cycle. s_ready stays low from the clear's acceptance
// until the sweep ends. The same sweep runs after reset before the first transaction is taken.
// The count outputs always show the counters as of the result being presented.

module direct_mapped_depth_preferred_table_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dmdpt_pkg::kind_t   s_kind,
    input  logic [63:0]        s_key_hash,
    input  logic signed [31:0] s_new_score,
    input  logic [7:0]         s_new_depth,
    input  logic [7:0]         s_new_node_type,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic signed [31:0] m_entry_score,
    output logic [7:0]         m_entry_depth,
    output logic [7:0]         m_entry_node_type,
    output logic               m_was_written,
    output logic [31:0]        m_hit_count,
    output logic [31:0]        m_miss_count,
    output logic [31:0]        m_conflict_count,
    output logic [31:0]        m_replace_count,
    output logic [31:0]        m_write_count
);

    import dmdpt_pkg::*;

    function automatic logic [31:0] sat_inc(input logic [31:0] c, input logic en);
        return (en && (c != '1)) ? c + 32'd1 : c;
    endfunction

    // stage one: accepted transaction, ram data arrives alongside
    logic               st_valid_reg;
    kind_t              st_kind_reg;
    logic [63:0]        st_key_reg;
    logic signed [31:0] st_score_reg;
    logic [7:0]         st_depth_reg;
    logic [7:0]         st_type_reg;
    idx_t               st_idx_reg;

    // result register
    logic               res_valid_reg;
    logic               res_found_reg;
    logic signed [31:0] res_score_reg;
    logic [7:0]         res_depth_reg;
    logic [7:0]         res_type_reg;
    logic               res_written_reg;

    logic [31:0] hit_cnt_reg, hit_cnt_next;
    logic [31:0] miss_cnt_reg, miss_cnt_next;
    logic [31:0] confl_cnt_reg, confl_cnt_next;
    logic [31:0] repl_cnt_reg, repl_cnt_next;
    logic [31:0] wr_cnt_reg, wr_cnt_next;

    // last slot write, covers a read issued in the same cycle as that write
    logic   bp_valid_reg;
    idx_t   bp_idx_reg;
    entry_t bp_data_reg;

    logic sweep_reg;
    idx_t sweep_idx_reg;

    logic   accept;
    logic   advance;
    idx_t   s_idx;
    entry_t ram_rdata;
    entry_t cur;
    entry_t wr_entry;
    logic   key_match;
    logic   lookup_hit;
    logic   lookup_miss;
    logic   lookup_conflict;
    logic   do_write;
    logic   do_replace;
    logic   ram_we;
    idx_t   ram_waddr;
    entry_t ram_wdata;

    assign s_idx   = IDX_W'(s_key_hash % 64'(TABLE_ENTRIES));
    assign advance = st_valid_reg && (!res_valid_reg || m_ready);
    // a clear must finish its sweep before any later read is issued
    assign s_ready = !sweep_reg && !(st_valid_reg && (st_kind_reg == KIND_CLEAR))
                     && (!st_valid_reg || advance);
    assign accept  = s_valid && s_ready;

    assign cur       = (bp_valid_reg && (bp_idx_reg == st_idx_reg)) ? bp_data_reg : ram_rdata;
    assign key_match = (cur.key == st_key_reg);

    always_comb begin
        lookup_hit      = 1'b0;
        lookup_miss     = 1'b0;
        lookup_conflict = 1'b0;
        do_write        = 1'b0;
        do_replace      = 1'b0;
        unique case (st_kind_reg)
            KIND_LOOKUP: begin
                lookup_miss     = !cur.valid;
                lookup_conflict = cur.valid && !key_match;
                lookup_hit      = cur.valid && key_match;
            end
            KIND_STORE: begin
                // a deeper entry of another key is kept
                do_write   = !(cur.valid && !key_match && (cur.depth > st_depth_reg));
                do_replace = do_write && cur.valid && !key_match;
            end
            default: begin
            end
        endcase
    end

    assign wr_entry = '{valid: 1'b1, key: st_key_reg, score: st_score_reg,
                        depth: st_depth_reg, ntype: st_type_reg};

    assign ram_we    = sweep_reg || (advance && do_write);
    assign ram_waddr = sweep_reg ? sweep_idx_reg : st_idx_reg;
    assign ram_wdata = sweep_reg ? entry_t'('0) : wr_entry;

    dmdpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_idx),
        .rdata (ram_rdata)
    );

    assign hit_cnt_next   = sat_inc(hit_cnt_reg, advance && lookup_hit);
    assign miss_cnt_next  = sat_inc(miss_cnt_reg, advance && lookup_miss);
    assign confl_cnt_next = sat_inc(confl_cnt_reg, advance && lookup_conflict);
    assign repl_cnt_next  = sat_inc(repl_cnt_reg, advance && do_replace);
    assign wr_cnt_next    = sat_inc(wr_cnt_reg, advance && do_write);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (advance) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_kind_reg  <= s_kind;
            st_key_reg   <= s_key_hash;
            st_score_reg <= s_new_score;
            st_depth_reg <= s_new_depth;
            st_type_reg  <= s_new_node_type;
            st_idx_reg   <= s_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_found_reg   <= lookup_hit;
            res_score_reg   <= lookup_hit ? cur.score : '0;
            res_depth_reg   <= lookup_hit ? cur.depth : '0;
            res_type_reg    <= lookup_hit ? cur.ntype : '0;
            res_written_reg <= do_write;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            confl_cnt_reg <= '0;
            repl_cnt_reg  <= '0;
            wr_cnt_reg    <= '0;
        end else begin
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            confl_cnt_reg <= confl_cnt_next;
            repl_cnt_reg  <= repl_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_valid_reg <= 1'b0;
        end else if (sweep_reg) begin
            bp_valid_reg <= 1'b0;
        end else if (advance && do_write) begin
            bp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && do_write) begin
            bp_idx_reg  <= st_idx_reg;
            bp_data_reg <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
        end else if (sweep_reg) begin
            if (sweep_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                sweep_reg <= 1'b0;
            end
            sweep_idx_reg <= sweep_idx_reg + idx_t'(1);
        end else if (advance && (st_kind_reg == KIND_CLEAR)) begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
        end
    end

    assign m_valid           = res_valid_reg;
    assign m_found           = res_found_reg;
    assign m_entry_score     = res_score_reg;
    assign m_entry_depth     = res_depth_reg;
    assign m_entry_node_type = res_type_reg;
    assign m_was_written     = res_written_reg;
    assign m_hit_count       = hit_cnt_reg;
    assign m_miss_count      = miss_cnt_reg;
    assign m_conflict_count  = confl_cnt_reg;
    assign m_replace_count   = repl_cnt_reg;
    assign m_write_count     = wr_cnt_reg;

    // sweep owns the write port, so no transaction may sit in stage one meanwhile
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(sweep_reg && (st_valid_reg || s_ready)))
        else $error("transaction in flight during table sweep");

    // nothing is read behind a pending clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && (st_kind_reg == KIND_CLEAR)) |-> !s_ready)
        else $error("transaction accepted behind a clear");

    // a result never reports a hit and a write together
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_was_written))
        else $error("result reports hit and write together");

    // counters only move up
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((wr_cnt_reg >= $past(wr_cnt_reg))
                            && (hit_cnt_reg >= $past(hit_cnt_reg))))
        else $error("event counter went backwards");

endmodule

[hw/rtl/dmdpt_ram.sv]
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies

module dmdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
